[hw/rtl/assert_macros.svh]
// Assertion macros for the checker of the vector unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define VFA_ASSERT_NXT_NR(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/vfa_pkg.sv]
// Package with the constants, types and helper functions of the vector unit.
package vfa_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int WORD_W       = 32;
  localparam int LANES        = 4;
  localparam int OP_W         = 4;
  localparam int EPS_W        = 31;
  localparam int SCALAR_W     = 47;
  localparam int SQ_W         = 2 * WORD_W;
  localparam int SUM_W        = SQ_W + 1;
  localparam int DIFF_LIM     = 28;
  localparam int DSQ_W        = 2 * DIFF_LIM;
  localparam int DSUM_W       = DSQ_W + 2;
  localparam int ROOT_W       = WORD_W + 1;
  localparam int DVD_W        = WORD_W + FRAC_BITS;
  localparam int DVS_W        = ROOT_W;
  localparam int MERGE_STAGES = 2;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = DVD_W;
  localparam int PIPE_STAGES  = 1 + MERGE_STAGES + SQRT_STAGES + DIV_STAGES;

  typedef enum logic [OP_W-1:0] {
    OP_NEG  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_SCL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_SQR  = 4'd5,
    OP_MAG  = 4'd6,
    OP_NORM = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9
  } op_t;

  // What one lane hands to the merge stage and the sideband.
  typedef struct packed {
    logic [WORD_W-1:0] simple;
    logic [SQ_W-1:0]   sq;
    logic [DSQ_W-1:0]  dsq;
    logic              big;
    logic              neg;
    logic [DVD_W-1:0]  dvd;
  } lane_out_t;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic                         sneg;
    logic [WORD_W-1:0]            smag;
    logic [LANES-1:0]             a_neg;
    logic [LANES-1:0][DVD_W-1:0]  dvd;
    logic [LANES-1:0][WORD_W-1:0] simple;
  } sb_a_t;

  typedef struct packed {
    sb_a_t                 a;
    logic [SCALAR_W-1:0]   scalar;
    logic                  flag;
  } sb_b_t;

  typedef struct packed {
    logic                         use_div;
    logic [LANES-1:0]             res_neg;
    logic [LANES-1:0][WORD_W-1:0] simple;
    logic [SCALAR_W-1:0]          scalar;
    logic                         flag;
    logic                         derr;
  } sb_c_t;

  typedef struct packed {
    logic [LANES-1:0][WORD_W-1:0] r;
    logic [SCALAR_W-1:0]          scalar;
    logic                         flag;
    logic                         derr;
  } res_t;

  // Saturate a signed value to one signed word.
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [SQ_W-1:0] v);
    logic signed [SQ_W-1:0] hi;
    logic signed [SQ_W-1:0] lo;
    hi = (SQ_W'(1) <<< (WORD_W - 1)) - SQ_W'(1);
    lo = -hi - SQ_W'(1);
    if (v > hi) begin
      return hi[WORD_W-1:0];
    end else if (v < lo) begin
      return lo[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

  // Apply a sign to a quotient magnitude and saturate it to one word.
  function automatic logic [WORD_W-1:0] sat_quot(input logic [DVD_W-1:0] q, input logic neg);
    logic [DVD_W-1:0] lim;
    lim = DVD_W'(1) << (WORD_W - 1);
    if (!neg) begin
      if (q >= lim) begin
        return lim[WORD_W-1:0] - WORD_W'(1);
      end
      return q[WORD_W-1:0];
    end
    if (q > lim) begin
      return lim[WORD_W-1:0];
    end
    return ~q[WORD_W-1:0] + WORD_W'(1);
  endfunction

endpackage

[hw/rtl/vfa_if.sv]
// Stream interfaces for the request and result channels of the vector unit.
interface vfa_in_if import vfa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          req_type;
  logic signed [WORD_W-1:0] a_x;
  logic signed [WORD_W-1:0] a_y;
  logic signed [WORD_W-1:0] a_z;
  logic signed [WORD_W-1:0] a_w;
  logic signed [WORD_W-1:0] b_x;
  logic signed [WORD_W-1:0] b_y;
  logic signed [WORD_W-1:0] b_z;
  logic signed [WORD_W-1:0] b_w;
  logic signed [WORD_W-1:0] scalar_in;

  modport source (output valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  scalar_in, input ready);
  modport sink (input valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                scalar_in, output ready);
endinterface

interface vfa_out_if import vfa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] r_x;
  logic signed [WORD_W-1:0] r_y;
  logic signed [WORD_W-1:0] r_z;
  logic signed [WORD_W-1:0] r_w;
  logic [SCALAR_W-1:0]      scalar_out;
  logic                     compare_flag;
  logic                     div_error;

  modport source (output valid, r_x, r_y, r_z, r_w, scalar_out, compare_flag, div_error,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, scalar_out, compare_flag, div_error,
                output ready);
endinterface

[hw/rtl/vfa_lane.sv]
// One component lane: simple results, squares and divider operands, one register stage.
module vfa_lane import vfa_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [OP_W-1:0]          op,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  input  logic signed [WORD_W-1:0] s,
  output lane_out_t                lane_r
);

  logic [WORD_W-1:0]        a_mag;
  logic signed [WORD_W:0]   diff;
  logic [WORD_W:0]          d_mag;
  logic signed [SQ_W-1:0]   prod;
  lane_out_t                lane_nxt;

  // Magnitudes and the exact difference.
  always_comb begin
    a_mag = a[WORD_W-1] ? WORD_W'(-{a[WORD_W-1], a}) : a;
    diff  = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    d_mag = diff[WORD_W] ? WORD_W'(1) + ~diff : diff;
    prod  = SQ_W'(a) * SQ_W'(s);
  end

  // Per-lane results.
  always_comb begin
    lane_nxt.sq  = SQ_W'(a_mag) * SQ_W'(a_mag);
    lane_nxt.big = |d_mag[WORD_W:DIFF_LIM];
    lane_nxt.dsq = DSQ_W'(d_mag[DIFF_LIM-1:0]) * DSQ_W'(d_mag[DIFF_LIM-1:0]);
    lane_nxt.neg = a[WORD_W-1];
    lane_nxt.dvd = {a_mag, FRAC_BITS'(0)};
    unique case (op)
      OP_NEG:  lane_nxt.simple = sat_word(-SQ_W'(a));
      OP_ADD:  lane_nxt.simple = sat_word(SQ_W'(a) + SQ_W'(b));
      OP_SUB:  lane_nxt.simple = sat_word(SQ_W'(a) - SQ_W'(b));
      OP_SCL:  lane_nxt.simple = sat_word(prod >>> FRAC_BITS);
      default: lane_nxt.simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

[hw/rtl/vfa_merge.sv]
// Two-stage adder tree that sums the squares and squared differences found by the four lanes.
module vfa_merge import vfa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  lane_out_t         lane [LANES],
  output logic [SUM_W-1:0]  sum_sq_r,
  output logic [DSUM_W-1:0] sum_d_r,
  output logic              big_r
);

  logic [SUM_W-2+1:0]   p0_r;
  logic [SUM_W-2+1:0]   p1_r;
  logic [DSUM_W-2:0]    dp0_r;
  logic [DSUM_W-2:0]    dp1_r;
  logic                 bg_r;

  // Pairwise sums, then the totals.
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r     <= SUM_W'(lane[0].sq) + SUM_W'(lane[1].sq);
      p1_r     <= SUM_W'(lane[2].sq) + SUM_W'(lane[3].sq);
      dp0_r    <= (DSUM_W-1)'(lane[0].dsq) + (DSUM_W-1)'(lane[1].dsq);
      dp1_r    <= (DSUM_W-1)'(lane[2].dsq) + (DSUM_W-1)'(lane[3].dsq);
      bg_r     <= lane[0].big | lane[1].big | lane[2].big | lane[3].big;
      sum_sq_r <= p0_r + p1_r;
      sum_d_r  <= DSUM_W'(dp0_r) + DSUM_W'(dp1_r);
      big_r    <= bg_r;
    end
  end

endmodule

[hw/rtl/vfa_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module vfa_sqrt import vfa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  n,
  output logic [ROOT_W-1:0] root
);

  localparam int T_W = SUM_W + 3;

  logic [SUM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    localparam int K = SQRT_STAGES - 1 - i;
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [T_W-1:0]    trial;
    logic [SUM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = n;
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // Setting bit K grows the square by 2^(K+1)*root + 2^(2K).
    always_comb begin
      trial    = (T_W'(root_in) << (K + 1)) + (T_W'(1) << (2 * K));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (T_W'(rem_in) >= trial) begin
        rem_nxt  = rem_in - trial[SUM_W-1:0];
        root_nxt = root_in | (ROOT_W'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

[hw/rtl/vfa_div.sv]
// Pipelined restoring divider for one lane, one quotient bit per stage.
module vfa_div import vfa_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quot
);

  logic [DVS_W-1:0] rem_r [DIV_STAGES];
  logic [DVD_W-1:0] dq_r  [DIV_STAGES];
  logic [DVS_W-1:0] dvs_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [DVS_W-1:0] rem_in;
    logic [DVD_W-1:0] dq_in;
    logic [DVS_W-1:0] dvs_in;
    logic [DVS_W:0]   shifted;
    logic [DVS_W-1:0] rem_nxt;
    logic             qbit;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dvs_in = divisor;
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign dq_in  = dq_r[i-1];
      assign dvs_in = dvs_r[i-1];
    end

    // Bring down the next dividend bit and try a subtract.
    always_comb begin
      shifted = {rem_in, dq_in[DVD_W-1]};
      qbit    = shifted >= {1'b0, dvs_in};
      rem_nxt = qbit ? DVS_W'(shifted - {1'b0, dvs_in}) : DVS_W'(shifted);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        dq_r[i]  <= {dq_in[DVD_W-2:0], qbit};
        dvs_r[i] <= dvs_in;
      end
    end
  end

  assign quot = dq_r[DIV_STAGES-1];

endmodule

[hw/rtl/vec4_fixed_point_alu.sv]
// Four-component Q16.16 vector unit. It takes one item per cycle while the output buffer has
// room and passes it through one lane stage, a two-stage merge tree, a 33-stage square root
// and a 48-stage divider, then a two-entry output buffer. Every item runs the full pipeline,
// so results leave in order. The pipeline halts only when both output buffer entries are
// full; with one result waiting, new items are still accepted. eps_r resets to 1.
module vec4_fixed_point_alu import vfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  vfa_in_if.sink           in_if,
  vfa_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [EPS_W-1:0] cfg_wdata
);

  logic [EPS_W-1:0]       eps_r;
  logic                   en;
  logic [PIPE_STAGES-1:0] vld_r;

  logic signed [WORD_W-1:0] a_in [LANES];
  logic signed [WORD_W-1:0] b_in [LANES];
  lane_out_t                lane [LANES];

  logic [OP_W-1:0]   op1_r;
  logic              sneg1_r;
  logic [WORD_W-1:0] smag1_r;
  logic [WORD_W-1:0] smag;

  sb_a_t a_s1;
  sb_a_t a_line_r [MERGE_STAGES];
  sb_b_t b_s3;
  sb_b_t b_line_r [SQRT_STAGES];
  sb_c_t c_s36;
  sb_c_t c_line_r [DIV_STAGES];

  logic [SUM_W-1:0]           sum_sq;
  logic [DSUM_W-1:0]          sum_d;
  logic                       big_any;
  logic [SUM_W-FRAC_BITS-1:0] sqr_full;
  logic                       near;
  logic [ROOT_W-1:0]          root;
  logic [DVS_W-1:0]           divisor;
  logic [DVD_W-1:0]           quot [LANES];
  res_t                       res;

  res_t       fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // The whole pipeline moves while the output buffer has room.
  assign en          = (cnt_r != 2'd2);
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_STAGES-2:0], in_if.valid};
    end
  end

  // Lane operands.
  assign a_in[0] = in_if.a_x;
  assign a_in[1] = in_if.a_y;
  assign a_in[2] = in_if.a_z;
  assign a_in[3] = in_if.a_w;
  assign b_in[0] = in_if.b_x;
  assign b_in[1] = in_if.b_y;
  assign b_in[2] = in_if.b_z;
  assign b_in[3] = in_if.b_w;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vfa_lane u_lane (
      .clk    (clk),
      .en     (en),
      .op     (in_if.req_type),
      .a      (a_in[i]),
      .b      (b_in[i]),
      .s      (in_if.scalar_in),
      .lane_r (lane[i])
    );
  end

  // Scalar magnitude and operation, registered beside the lanes.
  assign smag = in_if.scalar_in[WORD_W-1] ?
                WORD_W'(-{in_if.scalar_in[WORD_W-1], in_if.scalar_in}) : in_if.scalar_in;

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= in_if.req_type;
      sneg1_r <= in_if.scalar_in[WORD_W-1];
      smag1_r <= smag;
    end
  end

  always_comb begin
    a_s1.op   = op1_r;
    a_s1.sneg = sneg1_r;
    a_s1.smag = smag1_r;
    for (int i = 0; i < LANES; i++) begin
      a_s1.a_neg[i]  = lane[i].neg;
      a_s1.dvd[i]    = lane[i].dvd;
      a_s1.simple[i] = lane[i].simple;
    end
  end

  vfa_merge u_merge (
    .clk      (clk),
    .en       (en),
    .lane     (lane),
    .sum_sq_r (sum_sq),
    .sum_d_r  (sum_d),
    .big_r    (big_any)
  );

  // Squared magnitude and the equality test once the sums are in.
  always_comb begin
    sqr_full = sum_sq[SUM_W-1:FRAC_BITS];
    near     = !big_any && (sum_d < (DSUM_W'(eps_r) << FRAC_BITS));
    b_s3.a   = a_line_r[MERGE_STAGES-1];
    b_s3.scalar = '0;
    b_s3.flag   = 1'b0;
    if (a_line_r[MERGE_STAGES-1].op == OP_SQR) begin
      b_s3.scalar = (|sqr_full[SUM_W-FRAC_BITS-1:SCALAR_W]) ? '1 : sqr_full[SCALAR_W-1:0];
    end
    if (a_line_r[MERGE_STAGES-1].op == OP_EQ) begin
      b_s3.flag = near;
    end else if (a_line_r[MERGE_STAGES-1].op == OP_NE) begin
      b_s3.flag = !near;
    end
  end

  vfa_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (sum_sq),
    .root (root)
  );

  // Divider setup: scalar divisor or magnitude, with their guards.
  always_comb begin
    c_s36.simple  = b_line_r[SQRT_STAGES-1].a.simple;
    c_s36.flag    = b_line_r[SQRT_STAGES-1].flag;
    c_s36.scalar  = b_line_r[SQRT_STAGES-1].scalar;
    c_s36.derr    = 1'b0;
    c_s36.use_div = 1'b0;
    divisor       = root;
    if (b_line_r[SQRT_STAGES-1].a.op == OP_MAG) begin
      c_s36.scalar = SCALAR_W'(root);
    end
    if (b_line_r[SQRT_STAGES-1].a.op == OP_DIV) begin
      divisor       = DVS_W'(b_line_r[SQRT_STAGES-1].a.smag);
      c_s36.derr    = b_line_r[SQRT_STAGES-1].a.smag <= WORD_W'(eps_r);
      c_s36.use_div = !c_s36.derr;
    end
    if (b_line_r[SQRT_STAGES-1].a.op == OP_NORM) begin
      c_s36.use_div = root > ROOT_W'(eps_r);
    end
    for (int i = 0; i < LANES; i++) begin
      c_s36.res_neg[i] = b_line_r[SQRT_STAGES-1].a.a_neg[i] ^
                         ((b_line_r[SQRT_STAGES-1].a.op == OP_DIV) &
                          b_line_r[SQRT_STAGES-1].a.sneg);
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    vfa_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (b_line_r[SQRT_STAGES-1].a.dvd[i]),
      .divisor  (divisor),
      .quot     (quot[i])
    );
  end

  // Sideband delay lines that keep pace with the merge, root and divider stages.
  always_ff @(posedge clk) begin
    if (en) begin
      a_line_r[0] <= a_s1;
      for (int i = 1; i < MERGE_STAGES; i++) begin
        a_line_r[i] <= a_line_r[i-1];
      end
      b_line_r[0] <= b_s3;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        b_line_r[i] <= b_line_r[i-1];
      end
      c_line_r[0] <= c_s36;
      for (int i = 1; i < DIV_STAGES; i++) begin
        c_line_r[i] <= c_line_r[i-1];
      end
    end
  end

  // Final selection and saturation of the quotients.
  always_comb begin
    res.scalar = c_line_r[DIV_STAGES-1].scalar;
    res.flag   = c_line_r[DIV_STAGES-1].flag;
    res.derr   = c_line_r[DIV_STAGES-1].derr;
    for (int i = 0; i < LANES; i++) begin
      res.r[i] = c_line_r[DIV_STAGES-1].use_div ?
                 sat_quot(quot[i], c_line_r[DIV_STAGES-1].res_neg[i]) :
                 c_line_r[DIV_STAGES-1].simple[i];
    end
  end

  // Two-entry output buffer.
  assign push = en && vld_r[PIPE_STAGES-1];
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign out_if.valid        = (cnt_r != 2'd0);
  assign out_if.r_x          = fifo_r[rd_ptr_r].r[0];
  assign out_if.r_y          = fifo_r[rd_ptr_r].r[1];
  assign out_if.r_z          = fifo_r[rd_ptr_r].r[2];
  assign out_if.r_w          = fifo_r[rd_ptr_r].r[3];
  assign out_if.scalar_out   = fifo_r[rd_ptr_r].scalar;
  assign out_if.compare_flag = fifo_r[rd_ptr_r].flag;
  assign out_if.div_error    = fifo_r[rd_ptr_r].derr;

endmodule

[hw/rtl/vfa_checker.sv]
// Port-level checker for the vector unit and its bind to the top level.
`include "assert_macros.svh"

module vfa_checker import vfa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [WORD_W-1:0]   r_x,
  input logic [WORD_W-1:0]   r_y,
  input logic [WORD_W-1:0]   r_z,
  input logic [WORD_W-1:0]   r_w,
  input logic [SCALAR_W-1:0] scalar_out,
  input logic                compare_flag,
  input logic                div_error
);

  // A stalled result stays valid and holds r_x, r_w, scalar_out and compare_flag.
  `VFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(r_x) && $stable(r_w) && $stable(scalar_out) && $stable(compare_flag), "result changed while stalled")

  // A guarded divide returns nothing but the error flag.
  `VFA_ASSERT_IMP(a_derr_zero, clk, rst_n, out_valid && div_error, r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0 && scalar_out == '0 && !compare_flag, "divide error with nonzero fields")

  // A scalar result comes alone.
  `VFA_ASSERT_IMP(a_scalar_alone, clk, rst_n, out_valid && scalar_out != '0, r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0 && !compare_flag && !div_error, "scalar result mixed with other fields")

  // Reset empties the pipeline and output buffer.
  `VFA_ASSERT_NXT_NR(a_reset_empty, clk, !rst_n, !out_valid && in_ready, "unit not empty after reset")

endmodule

bind vec4_fixed_point_alu vfa_checker u_vfa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .r_x          (out_if.r_x),
  .r_y          (out_if.r_y),
  .r_z          (out_if.r_z),
  .r_w          (out_if.r_w),
  .scalar_out   (out_if.scalar_out),
  .compare_flag (out_if.compare_flag),
  .div_error    (out_if.div_error)
);

[sim/vec4_fixed_point_alu_test.sv]
// Self-checking testbench for the four-component fixed-point vector unit.
module vec4_fixed_point_alu_test import vfa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [OP_W-1:0] op;
    int              a[LANES];
    int              b[LANES];
    int              s;
  } vec_req_t;

  typedef struct {
    logic [WORD_W-1:0]   r[LANES];
    logic [SCALAR_W-1:0] scalar;
    logic                flag;
    logic                derr;
  } vec_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [EPS_W-1:0] cfg_wdata;

  vfa_in_if  in_if();
  vfa_out_if out_if();

  vec4_fixed_point_alu u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  vec_req_t pending_q[$];
  vec_res_t awaited_q[$];
  vec_req_t shown_req;
  logic [EPS_W-1:0] eps_val;
  bit steady;
  int fail_count;
  int stall_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate an exact value to one signed word.
  function automatic logic [WORD_W-1:0] clamp_word(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[WORD_W-1:0];
  endfunction

  // Integer square root, exact on sums up to 2^64.
  function automatic logic [65:0] root_floor(input logic [65:0] n);
    logic [67:0] res;
    logic [67:0] bitv;
    logic [67:0] rem;
    res = '0;
    rem = {2'b00, n};
    bitv = 68'd1 << 64;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[65:0];
  endfunction

  function automatic logic [65:0] square_sum(input vec_req_t q);
    logic [65:0] acc;
    longint unsigned m;
    acc = '0;
    for (int i = 0; i < LANES; i++) begin
      m = (q.a[i] < 0) ? longint'(-longint'(q.a[i])) : longint'(q.a[i]);
      acc += 66'(m * m);
    end
    return acc;
  endfunction

  // Expected result of one request item under the current tolerance.
  function automatic vec_res_t alu_predict(input vec_req_t q);
    vec_res_t x;
    longint sv;
    longint unsigned dsum;
    longint unsigned d;
    logic [65:0] mag;
    logic [65:0] t;
    bit near;
    x.scalar = '0;
    x.flag = 1'b0;
    x.derr = 1'b0;
    for (int i = 0; i < LANES; i++) x.r[i] = '0;
    sv = longint'(q.s);
    case (q.op)
      OP_NEG: for (int i = 0; i < LANES; i++) x.r[i] = clamp_word(-longint'(q.a[i]));
      OP_ADD: for (int i = 0; i < LANES; i++)
        x.r[i] = clamp_word(longint'(q.a[i]) + longint'(q.b[i]));
      OP_SUB: for (int i = 0; i < LANES; i++)
        x.r[i] = clamp_word(longint'(q.a[i]) - longint'(q.b[i]));
      OP_SCL: for (int i = 0; i < LANES; i++)
        x.r[i] = clamp_word((longint'(q.a[i]) * sv) >>> FRAC_BITS);
      OP_DIV: begin
        if (((sv < 0) ? -sv : sv) <= longint'(eps_val)) begin
          x.derr = 1'b1;
        end else begin
          for (int i = 0; i < LANES; i++)
            x.r[i] = clamp_word((longint'(q.a[i]) <<< FRAC_BITS) / sv);
        end
      end
      OP_SQR: begin
        t = square_sum(q) >> FRAC_BITS;
        x.scalar = (t > 66'h7fffffffffff) ? 47'h7fffffffffff : t[SCALAR_W-1:0];
      end
      OP_MAG: begin
        t = root_floor(square_sum(q));
        x.scalar = t[SCALAR_W-1:0];
      end
      OP_NORM: begin
        mag = root_floor(square_sum(q));
        if (mag > 66'(eps_val)) begin
          for (int i = 0; i < LANES; i++)
            x.r[i] = clamp_word((longint'(q.a[i]) <<< FRAC_BITS) / longint'(mag));
        end
      end
      OP_EQ, OP_NE: begin
        near = 1'b1;
        dsum = 0;
        for (int i = 0; i < LANES; i++) begin
          sv = longint'(q.a[i]) - longint'(q.b[i]);
          d = (sv < 0) ? -sv : sv;
          if (d >= (64'd1 << 28)) near = 1'b0;
          else dsum += d * d;
        end
        if (near) near = dsum < (longint'(eps_val) << FRAC_BITS);
        x.flag = (q.op == OP_EQ) ? near : !near;
      end
      default: ;
    endcase
    return x;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Request driver: records accepted items and presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) awaited_q.push_back(alu_predict(shown_req));
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 36)) begin
          shown_req = pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.req_type <= shown_req.op;
          in_if.a_x <= shown_req.a[0];
          in_if.a_y <= shown_req.a[1];
          in_if.a_z <= shown_req.a[2];
          in_if.a_w <= shown_req.a[3];
          in_if.b_x <= shown_req.b[0];
          in_if.b_y <= shown_req.b[1];
          in_if.b_z <= shown_req.b[2];
          in_if.b_w <= shown_req.b[3];
          in_if.scalar_in <= shown_req.s;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted item with the oldest expectation.
  always @(posedge clk) begin
    vec_res_t w;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = awaited_q.pop_front();
          if (out_if.r_x !== w.r[0]) report_mismatch("r_x", out_if.r_x, w.r[0]);
          if (out_if.r_y !== w.r[1]) report_mismatch("r_y", out_if.r_y, w.r[1]);
          if (out_if.r_z !== w.r[2]) report_mismatch("r_z", out_if.r_z, w.r[2]);
          if (out_if.r_w !== w.r[3]) report_mismatch("r_w", out_if.r_w, w.r[3]);
          if (out_if.scalar_out !== w.scalar)
            report_mismatch("scalar_out", out_if.scalar_out, w.scalar);
          if (out_if.compare_flag !== w.flag)
            report_mismatch("compare_flag", out_if.compare_flag, w.flag);
          if (out_if.div_error !== w.derr)
            report_mismatch("div_error", out_if.div_error, w.derr);
        end
      end
      out_if.ready <= steady || ($urandom_range(0, 99) >= 36);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Random word with a bias toward small, unit-scale and extreme values.
  function automatic int pick_word();
    case ($urandom_range(0, 6))
      0, 1: return int'($urandom);
      2: return $signed($urandom_range(0, 262143)) - 131072;
      3: return $signed($urandom_range(0, 33554431)) - 16777216;
      4: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 0;
          3: return -1;
          4: return 1;
          default: return 32'h00010000;
        endcase
      end
      5: return $signed($urandom_range(0, 8191)) - 4096;
      default: return $urandom_range(0, 1) ? 32'h00010000 : -32'sd65536;
    endcase
  endfunction

  function automatic vec_req_t make_req(input logic [OP_W-1:0] op, input int a0, input int a1,
                                        input int a2, input int a3, input int b0, input int b1,
                                        input int b2, input int b3, input int s);
    vec_req_t q;
    q.op = op;
    q.a[0] = a0; q.a[1] = a1; q.a[2] = a2; q.a[3] = a3;
    q.b[0] = b0; q.b[1] = b1; q.b[2] = b2; q.b[3] = b3;
    q.s = s;
    return q;
  endfunction

  // Random item; comparisons mostly use a nearby second vector.
  function automatic vec_req_t random_req();
    vec_req_t q;
    int sp;
    int lim;
    q.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
    for (int i = 0; i < LANES; i++) begin
      q.a[i] = pick_word();
      q.b[i] = pick_word();
    end
    q.s = pick_word();
    if ((q.op == OP_EQ || q.op == OP_NE) && $urandom_range(0, 3) != 0) begin
      sp = 1 << $urandom_range(0, 27);
      for (int i = 0; i < LANES; i++)
        q.b[i] = int'(longint'(q.a[i]) + $signed($urandom_range(0, sp)) - sp / 2);
    end
    // Divisors straddling the guard band around zero.
    if (q.op == OP_DIV && $urandom_range(0, 4) == 0) begin
      lim = (eps_val > 1000) ? 1000 : int'(eps_val);
      q.s = $signed($urandom_range(0, 2 * lim + 2)) - lim - 1;
    end
    return q;
  endfunction

  task automatic write_eps(input logic [EPS_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_val = v;
  endtask

  // Wait until every queued item is accepted and every result has come back.
  task automatic drain();
    wait (pending_q.size() == 0 && !in_if.valid && awaited_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    logic [EPS_W-1:0] eps_steps[5];
    int mx;
    int mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    fail_count = 0;
    stall_cycles = 0;
    steady = 1'b0;
    eps_val = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.req_type = '0;
    in_if.a_x = '0; in_if.a_y = '0; in_if.a_z = '0; in_if.a_w = '0;
    in_if.b_x = '0; in_if.b_y = '0; in_if.b_z = '0; in_if.b_w = '0;
    in_if.scalar_in = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset tolerance.
    pending_q.push_back(make_req(OP_NEG, mn, mx, 0, -1, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_ADD, mx, mn, 5, -7, mx, mn, -5, 3, 0));
    pending_q.push_back(make_req(OP_SUB, mn, mx, 9, -2, mx, mn, 4, 8, 0));
    pending_q.push_back(make_req(OP_SCL, mx, mn, 65536, -3, 0, 0, 0, 0, mx));
    pending_q.push_back(make_req(OP_SCL, mn, mx, -1, 1, 0, 0, 0, 0, mn));
    pending_q.push_back(make_req(OP_DIV, 65536, -65536, mx, mn, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_DIV, 65536, -65536, mx, mn, 0, 0, 0, 0, -1));
    pending_q.push_back(make_req(OP_DIV, 65536, -65536, mx, mn, 0, 0, 0, 0, 2));
    pending_q.push_back(make_req(OP_DIV, 7, -9, mx, mn, 0, 0, 0, 0, mn));
    pending_q.push_back(make_req(OP_SQR, mn, mn, mn, mn, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_SQR, 65536, 65536, 0, 1, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_MAG, mn, mn, mn, mn, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_MAG, 3, 4, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_NORM, mx, 0, -5, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_NORM, mn, mn, mn, mn, 0, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_EQ, 5, 6, 7, 8, 5, 6, 7, 8, 0));
    pending_q.push_back(make_req(OP_EQ, 0, 0, 0, 0, 1 << 28, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_EQ, mx, 0, 0, 0, mn, 0, 0, 0, 0));
    pending_q.push_back(make_req(OP_NE, 5, 6, 7, 8, 5, 6, 7, 9, 0));
    pending_q.push_back(make_req(OP_NE, 1, 2, 3, 4, 1, 2, 3, 4, 0));
    pending_q.push_back(make_req(4'd10, mx, mx, mx, mx, mn, mn, mn, mn, mx));
    pending_q.push_back(make_req(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    drain();

    // Random phases across tolerance settings, one of them without idling.
    eps_steps[0] = 1;
    eps_steps[1] = 0;
    eps_steps[2] = 31'h7fffffff;
    eps_steps[3] = 31'd65536;
    eps_steps[4] = 31'($urandom);
    foreach (eps_steps[k]) begin
      write_eps(eps_steps[k]);
      steady = (k == 3);
      for (int n = 0; n < 290; n++) pending_q.push_back(random_req());
      drain();
    end
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
